// File: rtl/live_gene_mark_and_compact_top_assert.svh
// Assertion macros for the live-gene marker and compactor.
`ifndef LIVE_GENE_MARK_AND_COMPACT_TOP_ASSERT_SVH
`define LIVE_GENE_MARK_AND_COMPACT_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LGMC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LGMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lgmc_pkg.sv
// Types and constants shared by the live-gene marker and compactor.
package lgmc_pkg;

  // Sizes of the program stores.
  localparam int MAX_GENES   = 256;
  localparam int MAX_OUTPUTS = 16;
  localparam int GENE_AW     = $clog2(MAX_GENES);
  localparam int OUT_AW      = $clog2(MAX_OUTPUTS);
  localparam int LEN_W       = $clog2(MAX_GENES + 1);

  // Field widths.
  localparam int OPC_W   = 3;
  localparam int IDX_W   = 8;
  localparam int OP_W    = 16;
  localparam int AR_W    = 3;
  localparam int ADDR_W  = 8;
  localparam int OCNT_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 72;

  // An operator never uses more than four addresses.
  localparam logic [AR_W-1:0] MAX_ARITY = 3'd4;

  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [GENE_AW-1:0] gaddr_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [OCNT_W-1:0]  ocnt_t;

  // Command codes carried in tuser.
  typedef enum logic [OPC_W-1:0] {
    OPC_WRITE_GENE = 3'd0,
    OPC_WRITE_OUT  = 3'd1,
    OPC_ANALYSE    = 3'd2,
    OPC_READ_GENE  = 3'd3,
    OPC_READ_OUT   = 3'd4
  } opcode_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROGRAM_LENGTH = 2'd0,
    CFG_OUTPUT_COUNT   = 2'd1,
    CFG_LAST_SCANNED   = 2'd2,
    CFG_COUNT_ALL      = 2'd3
  } cfg_index_e;

  // One stored gene.
  typedef struct packed {
    logic signed [OP_W-1:0] op;
    logic [AR_W-1:0]        arity;
    logic [3:0][ADDR_W-1:0] addr;
  } gene_t;

  // One gene of the compacted program.
  typedef struct packed {
    logic signed [OP_W-1:0] op;
    logic [3:0][ADDR_W-1:0] addr;
  } cgene_t;

endpackage

// File: rtl/live_gene_mark_and_compact_top.sv
// Live-gene marker and compactor for a straight-line program: top level.
// Gene and output writes, output reads and unknown commands give a registered result in the
// cycle after the transfer; a compacted gene read passes the compacted memory read register,
// then the result register. Analyse seeds marks from the outputs, sweeps back, builds skip
// counts, compacts and remaps the outputs through the single gene and skip-count read ports.
// The block takes one command at a time. Reset restores the register defaults and clears
// the live count; the gene, skip and compacted stores are undefined until written.
`include "live_gene_mark_and_compact_top_assert.svh"

module live_gene_mark_and_compact_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [lgmc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lgmc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Command stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // index, gene_op, arity, addr_a, addr_b, addr_c, addr_d, zero padding
  input  logic [lgmc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // opcode
  input  logic [lgmc_pkg::OPC_W-1:0]          s_axis_tuser,
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // used_genes, out_op, out_addr_a, out_addr_b, out_addr_c, out_addr_d,
  // out_gene_index, zero padding
  output logic [lgmc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SEED,
    S_SW_RD,
    S_SW_CHK,
    S_SW_MK,
    S_PREFIX,
    S_CP_CHK,
    S_CP_GENE,
    S_CP_SKRD,
    S_CP_SKWR,
    S_OR_RD,
    S_OR_WR
  } state_e;

  // Clamp an address to the last gene of the program.
  function automatic lgmc_pkg::gaddr_t clamp_addr(input lgmc_pkg::addr_t a,
                                                  input lgmc_pkg::len_t n);
    lgmc_pkg::len_t a_ext;
    a_ext = lgmc_pkg::len_t'(a);
    if (a_ext >= n) begin
      a_ext = n - 1'b1;
    end
    return a_ext[lgmc_pkg::GENE_AW-1:0];
  endfunction

  // Configuration registers
  lgmc_pkg::len_t  prog_len_q;
  lgmc_pkg::ocnt_t out_cnt_q;
  lgmc_pkg::addr_t last_scan_q;
  logic            count_all_q;

  // Sequencer and result registers
  state_e                          state_q, state_d;
  lgmc_pkg::len_t                  cnt_q, cnt_d;
  logic [1:0]                      k_q, k_d;
  lgmc_pkg::len_t                  unm_q, unm_d;
  lgmc_pkg::len_t                  kept_q, kept_d;
  lgmc_pkg::len_t                  live_q, live_d;
  logic [3:0][lgmc_pkg::ADDR_W-1:0] lowered_q, lowered_d;
  logic                            rd_ok_q, rd_ok_d;
  logic [lgmc_pkg::MAX_GENES-1:0]  marks_q, marks_d;
  logic                            mvalid_q, mvalid_d;
  lgmc_pkg::len_t                  out_used_q, out_used_d;
  logic signed [lgmc_pkg::OP_W-1:0] out_op_q, out_op_d;
  logic [3:0][lgmc_pkg::ADDR_W-1:0] out_addr_q, out_addr_d;
  lgmc_pkg::addr_t                 out_gidx_q, out_gidx_d;

  // Memories and small register files
  lgmc_pkg::gene_t  gene_mem [lgmc_pkg::MAX_GENES];
  lgmc_pkg::len_t   skip_mem [lgmc_pkg::MAX_GENES];
  lgmc_pkg::cgene_t cmp_mem  [lgmc_pkg::MAX_GENES];
  lgmc_pkg::addr_t  og_mem   [lgmc_pkg::MAX_OUTPUTS];
  lgmc_pkg::addr_t  cout_mem [lgmc_pkg::MAX_OUTPUTS];

  lgmc_pkg::gene_t  gene_rd_q;
  lgmc_pkg::len_t   skip_rd_q;
  lgmc_pkg::cgene_t cmp_rd_q;

  // Memory port controls
  logic             gene_we, gene_re;
  lgmc_pkg::gaddr_t gene_raddr;
  logic             skip_we, skip_re;
  lgmc_pkg::gaddr_t skip_waddr, skip_raddr;
  lgmc_pkg::len_t   skip_wdata;
  logic             cmp_we, cmp_re;
  lgmc_pkg::gaddr_t cmp_waddr, cmp_raddr;
  lgmc_pkg::cgene_t cmp_wdata;
  logic             og_we, cout_we;
  lgmc_pkg::addr_t  cout_wdata;
  logic             mark_we, mark_clr;
  lgmc_pkg::addr_t  mark_waddr;

  // Result loading
  logic                             res_load;
  logic signed [lgmc_pkg::OP_W-1:0] res_op;
  logic [3:0][lgmc_pkg::ADDR_W-1:0] res_addr;
  lgmc_pkg::addr_t                  res_gidx;

  // Input fields
  logic                             accept;
  lgmc_pkg::opcode_e                in_opc;
  lgmc_pkg::addr_t                  in_index;
  lgmc_pkg::gene_t                  in_gene;

  // Derived values
  lgmc_pkg::len_t                   len;
  lgmc_pkg::ocnt_t                  outs;
  lgmc_pkg::len_t                   scan_end;
  logic [lgmc_pkg::AR_W-1:0]        ar;
  lgmc_pkg::addr_t                  sel_addr;
  lgmc_pkg::addr_t                  og_sel;
  logic                             cur_mark;
  lgmc_pkg::addr_t                  lowered;
  lgmc_pkg::addr_t                  out_skip;

  // Unpack the command.
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_opc        = lgmc_pkg::opcode_e'(s_axis_tuser);
  assign in_index      = s_axis_tdata[7:0];
  assign in_gene.op    = s_axis_tdata[23:8];
  assign in_gene.arity = s_axis_tdata[26:24];
  assign in_gene.addr  = s_axis_tdata[58:27];

  // Program size, scan limit and the operand being worked on.
  assign len      = (prog_len_q > lgmc_pkg::len_t'(lgmc_pkg::MAX_GENES)) ?
                    lgmc_pkg::len_t'(lgmc_pkg::MAX_GENES) : prog_len_q;
  assign outs     = (out_cnt_q > lgmc_pkg::ocnt_t'(lgmc_pkg::MAX_OUTPUTS)) ?
                    lgmc_pkg::ocnt_t'(lgmc_pkg::MAX_OUTPUTS) : out_cnt_q;
  assign scan_end = (lgmc_pkg::len_t'(last_scan_q) < len) ?
                    lgmc_pkg::len_t'(last_scan_q) + 1'b1 : len;
  assign ar       = (gene_rd_q.arity > lgmc_pkg::MAX_ARITY) ?
                    lgmc_pkg::MAX_ARITY : gene_rd_q.arity;
  assign sel_addr = gene_rd_q.addr[k_q];
  assign og_sel   = og_mem[cnt_q[lgmc_pkg::OUT_AW-1:0]];
  assign cur_mark = marks_q[cnt_q[lgmc_pkg::GENE_AW-1:0]];
  assign lowered  = sel_addr - skip_rd_q[lgmc_pkg::ADDR_W-1:0];
  assign out_skip = (len == '0) ? '0 : skip_rd_q[lgmc_pkg::ADDR_W-1:0];

  // Handshakes and packed result.
  assign s_axis_tready = (state_q == S_IDLE) && (!mvalid_q || m_axis_tready);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {7'b0, out_gidx_q, out_addr_q, out_op_q, out_used_q};

  // Sequencer: command decode, marking, skip prefix, compaction and output remap.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    unm_d      = unm_q;
    kept_d     = kept_q;
    live_d     = live_q;
    lowered_d  = lowered_q;
    rd_ok_d    = rd_ok_q;
    mvalid_d   = mvalid_q && !m_axis_tready;
    out_used_d = out_used_q;
    out_op_d   = out_op_q;
    out_addr_d = out_addr_q;
    out_gidx_d = out_gidx_q;
    gene_we    = 1'b0;
    gene_re    = 1'b0;
    gene_raddr = cnt_q[lgmc_pkg::GENE_AW-1:0];
    skip_we    = 1'b0;
    skip_re    = 1'b0;
    skip_waddr = cnt_q[lgmc_pkg::GENE_AW-1:0];
    skip_raddr = clamp_addr(sel_addr, len);
    skip_wdata = unm_q;
    cmp_we     = 1'b0;
    cmp_re     = 1'b0;
    cmp_waddr  = kept_q[lgmc_pkg::GENE_AW-1:0];
    cmp_raddr  = in_index[lgmc_pkg::GENE_AW-1:0];
    cmp_wdata  = {gene_rd_q.op, gene_rd_q.addr};
    og_we      = 1'b0;
    cout_we    = 1'b0;
    cout_wdata = og_sel - out_skip;
    mark_we    = 1'b0;
    mark_clr   = 1'b0;
    mark_waddr = sel_addr;
    res_load   = 1'b0;
    res_op     = '0;
    res_addr   = '0;
    res_gidx   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_opc)
            lgmc_pkg::OPC_WRITE_GENE: begin
              gene_we  = lgmc_pkg::len_t'(in_index) <
                         lgmc_pkg::len_t'(lgmc_pkg::MAX_GENES);
              res_load = 1'b1;
            end
            lgmc_pkg::OPC_WRITE_OUT: begin
              og_we    = lgmc_pkg::len_t'(in_index) <
                         lgmc_pkg::len_t'(lgmc_pkg::MAX_OUTPUTS);
              res_load = 1'b1;
            end
            lgmc_pkg::OPC_ANALYSE: begin
              mark_clr = 1'b1;
              cnt_d    = '0;
              state_d  = S_SEED;
            end
            lgmc_pkg::OPC_READ_GENE: begin
              cmp_re  = 1'b1;
              rd_ok_d = lgmc_pkg::len_t'(in_index) <
                        lgmc_pkg::len_t'(lgmc_pkg::MAX_GENES);
              state_d = S_RD_WAIT;
            end
            lgmc_pkg::OPC_READ_OUT: begin
              res_load = 1'b1;
              if (lgmc_pkg::len_t'(in_index) <
                  lgmc_pkg::len_t'(lgmc_pkg::MAX_OUTPUTS)) begin
                res_gidx = cout_mem[in_index[lgmc_pkg::OUT_AW-1:0]];
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      // Compacted gene read data is now registered.
      S_RD_WAIT: begin
        res_load = 1'b1;
        if (rd_ok_q) begin
          res_op   = cmp_rd_q.op;
          res_addr = cmp_rd_q.addr;
        end
        state_d = S_IDLE;
      end

      // Seed marks from the output genes, one output a cycle.
      S_SEED: begin
        if (cnt_q == lgmc_pkg::len_t'(outs)) begin
          cnt_d   = len;
          state_d = S_SW_RD;
        end else begin
          mark_we    = lgmc_pkg::len_t'(og_sel) < len;
          mark_waddr = og_sel;
          cnt_d      = cnt_q + 1'b1;
        end
      end

      // Reverse sweep: fetch the next lower gene.
      S_SW_RD: begin
        if (cnt_q == '0) begin
          unm_d   = '0;
          state_d = S_PREFIX;
        end else begin
          gene_re    = 1'b1;
          gene_raddr = lgmc_pkg::gaddr_t'(cnt_q - 1'b1);
          cnt_d      = cnt_q - 1'b1;
          state_d    = S_SW_CHK;
        end
      end

      // Only a marked operator with operands propagates marks.
      S_SW_CHK: begin
        if (cur_mark && gene_rd_q.op[lgmc_pkg::OP_W-1] && (ar != '0)) begin
          k_d     = '0;
          state_d = S_SW_MK;
        end else begin
          state_d = S_SW_RD;
        end
      end

      // Mark one operand a cycle.
      S_SW_MK: begin
        mark_we = lgmc_pkg::len_t'(sel_addr) < len;
        if ({1'b0, k_q} == ar - 1'b1) begin
          state_d = S_SW_RD;
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      // Running count of unmarked genes, stored per gene.
      S_PREFIX: begin
        if (cnt_q == len) begin
          cnt_d   = '0;
          kept_d  = '0;
          state_d = S_CP_CHK;
        end else begin
          unm_d      = unm_q + lgmc_pkg::len_t'(!cur_mark);
          skip_we    = 1'b1;
          skip_wdata = unm_d;
          cnt_d      = cnt_q + 1'b1;
        end
      end

      // Compaction: step over unmarked genes, fetch marked ones.
      S_CP_CHK: begin
        if (cnt_q == scan_end) begin
          cnt_d   = '0;
          state_d = S_OR_RD;
        end else if (cur_mark) begin
          gene_re = 1'b1;
          state_d = S_CP_GENE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      // Terminals are copied as they are; operators get their addresses lowered.
      S_CP_GENE: begin
        if (gene_rd_q.op[lgmc_pkg::OP_W-1]) begin
          k_d     = '0;
          state_d = S_CP_SKRD;
        end else begin
          cmp_we  = 1'b1;
          kept_d  = kept_q + 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = S_CP_CHK;
        end
      end

      S_CP_SKRD: begin
        skip_re = 1'b1;
        state_d = S_CP_SKWR;
      end

      // Lower one address; write the gene after the fourth.
      S_CP_SKWR: begin
        lowered_d[k_q] = lowered;
        if (k_q == 2'd3) begin
          cmp_we    = 1'b1;
          cmp_wdata = {gene_rd_q.op, lowered_d};
          kept_d    = kept_q + 1'b1;
          cnt_d     = cnt_q + 1'b1;
          state_d   = S_CP_CHK;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_CP_SKRD;
        end
      end

      // Remap the output genes, then report the count.
      S_OR_RD: begin
        if (cnt_q == lgmc_pkg::len_t'(outs)) begin
          live_d   = count_all_q ? len : kept_q;
          res_load = 1'b1;
          state_d  = S_IDLE;
        end else begin
          skip_re    = 1'b1;
          skip_raddr = clamp_addr(og_sel, len);
          state_d    = S_OR_WR;
        end
      end

      S_OR_WR: begin
        cout_we = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        state_d = S_OR_RD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Live marks: cleared on analyse, set one at a time.
    marks_d = marks_q;
    if (mark_clr) begin
      marks_d = '0;
    end
    if (mark_we) begin
      marks_d[mark_waddr[lgmc_pkg::GENE_AW-1:0]] = 1'b1;
    end

    // Result register load.
    if (res_load) begin
      mvalid_d   = 1'b1;
      out_used_d = live_d;
      out_op_d   = res_op;
      out_addr_d = res_addr;
      out_gidx_d = res_gidx;
    end
  end

  // State, configuration and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q  <= lgmc_pkg::len_t'(1);
      out_cnt_q   <= lgmc_pkg::ocnt_t'(1);
      last_scan_q <= '0;
      count_all_q <= 1'b0;
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      unm_q       <= '0;
      kept_q      <= '0;
      live_q      <= '0;
      lowered_q   <= '0;
      rd_ok_q     <= 1'b0;
      marks_q     <= '0;
      mvalid_q    <= 1'b0;
      out_used_q  <= '0;
      out_op_q    <= '0;
      out_addr_q  <= '0;
      out_gidx_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          lgmc_pkg::CFG_PROGRAM_LENGTH: prog_len_q  <= cfg_data_i;
          lgmc_pkg::CFG_OUTPUT_COUNT:   out_cnt_q   <= cfg_data_i[lgmc_pkg::OCNT_W-1:0];
          lgmc_pkg::CFG_LAST_SCANNED:   last_scan_q <= cfg_data_i[lgmc_pkg::ADDR_W-1:0];
          lgmc_pkg::CFG_COUNT_ALL:      count_all_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      k_q        <= k_d;
      unm_q      <= unm_d;
      kept_q     <= kept_d;
      live_q     <= live_d;
      lowered_q  <= lowered_d;
      rd_ok_q    <= rd_ok_d;
      marks_q    <= marks_d;
      mvalid_q   <= mvalid_d;
      out_used_q <= out_used_d;
      out_op_q   <= out_op_d;
      out_addr_q <= out_addr_d;
      out_gidx_q <= out_gidx_d;
    end
  end

  // Gene memory: written by load commands, read by the sweep and compaction.
  always_ff @(posedge clk_i) begin
    if (gene_we) begin
      gene_mem[in_index[lgmc_pkg::GENE_AW-1:0]] <= in_gene;
    end
    if (gene_re) begin
      gene_rd_q <= gene_mem[gene_raddr];
    end
  end

  // Skip-count memory.
  always_ff @(posedge clk_i) begin
    if (skip_we) begin
      skip_mem[skip_waddr] <= skip_wdata;
    end
    if (skip_re) begin
      skip_rd_q <= skip_mem[skip_raddr];
    end
  end

  // Compacted program memory.
  always_ff @(posedge clk_i) begin
    if (cmp_we) begin
      cmp_mem[cmp_waddr] <= cmp_wdata;
    end
    if (cmp_re) begin
      cmp_rd_q <= cmp_mem[cmp_raddr];
    end
  end

  // Output gene lists, original and remapped.
  always_ff @(posedge clk_i) begin
    if (og_we) begin
      og_mem[in_index[lgmc_pkg::OUT_AW-1:0]] <= in_gene.addr[0];
    end
    if (cout_we) begin
      cout_mem[cnt_q[lgmc_pkg::OUT_AW-1:0]] <= cout_wdata;
    end
  end

  // Checks on the sequencer.
  `LGMC_ASSERT_SAME(a_busy_not_ready, state_q != S_IDLE, !s_axis_tready, "ready while busy")
  `LGMC_ASSERT_NEXT(a_analyse_clears, accept && (s_axis_tuser == lgmc_pkg::OPC_ANALYSE), (state_q == S_SEED) && (marks_q == '0), "analyse did not start clean")
  `LGMC_ASSERT_SAME(a_kept_bounded, state_q == S_CP_CHK, kept_q <= cnt_q, "kept more genes than scanned")
  `LGMC_ASSERT_SAME(a_mark_from_live, state_q == S_SW_MK, cur_mark && gene_rd_q.op[lgmc_pkg::OP_W-1], "marks spread from a dead gene")

endmodule
